>>> sv/csvfs_pkg.sv
`timescale 1ns / 1ps

package csvfs_pkg;

  // Default sizes of one line
  localparam int DEF_MAX_LINE   = 4096;
  localparam int DEF_MAX_FIELDS = 4096;

  // Register reset values and the fixed terminator byte
  localparam logic [7:0] SEP_RESET   = 8'd44;  // ','
  localparam logic [7:0] QUOTE_RESET = 8'd34;  // '"'
  localparam logic [7:0] TERM_CHAR   = 8'h00;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SEPARATOR = 1'b0,
    CFG_QUOTE     = 1'b1
  } cfg_idx_t;

  // Per-field status bits
  typedef struct packed {
    logic overflow;
    logic unbalanced;
    logic last_field;
  } field_flags_t;

endpackage

>>> sv/csvfs_core.sv
`timescale 1ns / 1ps

module csvfs_core #(
  parameter int MAX_LINE   = csvfs_pkg::DEF_MAX_LINE,
  parameter int MAX_FIELDS = csvfs_pkg::DEF_MAX_FIELDS,
  localparam int POS_W     = $clog2(MAX_LINE + 1),
  localparam int COL_W     = $clog2(MAX_FIELDS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  logic [7:0]              line_byte,
  input  logic [7:0]              separator_char,
  input  logic [7:0]              quote_char,
  output logic                    res_valid,
  output logic [POS_W-1:0]        res_start,
  output logic [POS_W-1:0]        res_end,
  output logic [COL_W-1:0]        res_column,
  output csvfs_pkg::field_flags_t res_flags
);

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE);
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_FIELDS - 1);

  logic             in_quotes_r, in_quotes_nxt;
  logic             quote_pend_r, quote_pend_nxt;
  logic             has_close_r, has_close_nxt;
  logic [POS_W-1:0] position_r, position_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [POS_W-1:0] close_pos_r, close_pos_nxt;
  logic [COL_W-1:0] column_r, column_nxt;
  logic             ovf_r, ovf_nxt;

  logic             is_term, is_quote, is_sep, dbl_quote;
  logic             pos_at_max, col_at_max;
  logic [POS_W-1:0] pos_inc;
  logic             inq1, hc1;
  logic [POS_W-1:0] cp1, end_raw;
  logic             emit;

  always_comb begin
    is_term    = (line_byte == csvfs_pkg::TERM_CHAR);
    is_quote   = !is_term && (line_byte == quote_char);
    is_sep     = !is_term && (line_byte == separator_char);
    dbl_quote  = quote_pend_r && is_quote;
    pos_at_max = (position_r == POS_MAX);
    col_at_max = (column_r == COL_MAX);
    pos_inc    = pos_at_max ? position_r : position_r + POS_W'(1);

    // A pending quote not followed by another closes the quoted section
    inq1 = quote_pend_r ? 1'b0 : in_quotes_r;
    hc1  = quote_pend_r ? 1'b1 : has_close_r;
    cp1  = close_pos_r;
    if (quote_pend_r) begin
      cp1 = (position_r == '0) ? '0 : position_r - POS_W'(1);
    end
    end_raw = hc1 ? cp1 : position_r;

    in_quotes_nxt  = in_quotes_r;
    quote_pend_nxt = quote_pend_r;
    has_close_nxt  = has_close_r;
    position_nxt   = position_r;
    start_nxt      = start_r;
    close_pos_nxt  = close_pos_r;
    column_nxt     = column_r;
    ovf_nxt        = ovf_r;
    emit           = 1'b0;
    res_flags      = '0;

    if (dbl_quote) begin
      quote_pend_nxt = 1'b0;
      position_nxt   = pos_inc;
      ovf_nxt        = ovf_r | pos_at_max;
    end else if (is_term) begin
      emit                 = 1'b1;
      res_flags.last_field = 1'b1;
      res_flags.unbalanced = inq1;
      res_flags.overflow   = ovf_r;
      in_quotes_nxt  = 1'b0;
      quote_pend_nxt = 1'b0;
      has_close_nxt  = 1'b0;
      position_nxt   = '0;
      start_nxt      = '0;
      close_pos_nxt  = '0;
      column_nxt     = '0;
      ovf_nxt        = 1'b0;
    end else begin
      in_quotes_nxt  = inq1;
      quote_pend_nxt = 1'b0;
      has_close_nxt  = hc1;
      close_pos_nxt  = cp1;
      position_nxt   = pos_inc;
      ovf_nxt        = ovf_r | pos_at_max;
      if (is_quote) begin
        if (!inq1) begin
          in_quotes_nxt = 1'b1;
          start_nxt     = pos_inc;
        end else begin
          quote_pend_nxt = 1'b1;
        end
      end else if (is_sep && !inq1) begin
        emit          = 1'b1;
        ovf_nxt       = ovf_r | pos_at_max | col_at_max;
        column_nxt    = col_at_max ? column_r : column_r + COL_W'(1);
        start_nxt     = pos_inc;
        has_close_nxt = 1'b0;
        res_flags.overflow = ovf_r | pos_at_max | col_at_max;
      end
    end

    res_valid  = step_en && emit;
    res_start  = start_r;
    res_end    = (end_raw < start_r) ? start_r : end_raw;
    res_column = column_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r  <= 1'b0;
      quote_pend_r <= 1'b0;
      has_close_r  <= 1'b0;
      position_r   <= '0;
      start_r      <= '0;
      close_pos_r  <= '0;
      column_r     <= '0;
      ovf_r        <= 1'b0;
    end else if (step_en) begin
      in_quotes_r  <= in_quotes_nxt;
      quote_pend_r <= quote_pend_nxt;
      has_close_r  <= has_close_nxt;
      position_r   <= position_nxt;
      start_r      <= start_nxt;
      close_pos_r  <= close_pos_nxt;
      column_r     <= column_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

endmodule

>>> sv/csv_field_splitter.sv
`timescale 1ns / 1ps

// csv_field_splitter: tokenizes a NUL-terminated CSV line, one byte per
// input transaction, and reports each field's bounds.
//
// Channels:
//   in_*   : one line byte per transaction; byte 0 ends the line.
//   out_*  : one transaction per field, on a separator outside quotes or
//            at the terminator. tlast marks the line's last field; tuser
//            carries the unbalanced-quote and overflow flags.
//   cfg_*  : register writes (separator and quote byte), always ready.
//            Write only while the block is idle.
// Throughput: one byte per cycle while in_tready is high. The quote/position
// state is registered and updated on every accepted byte.
// The byte that ends a field loads its result into the output register or skid.
// Stall: a two-entry output (register plus skid) keeps bytes flowing while
// one result waits; in_tready drops only once a second result fills the
// skid entry, and rises again the cycle after the waiting result is taken.
// Reset: synchronous; clears line state and output valids and restores
// the separator to ',' and the quote to '"'.
module csv_field_splitter #(
  parameter int MAX_LINE   = csvfs_pkg::DEF_MAX_LINE,
  parameter int MAX_FIELDS = csvfs_pkg::DEF_MAX_FIELDS,
  localparam int POS_W     = $clog2(MAX_LINE + 1),
  localparam int COL_W     = $clog2(MAX_FIELDS),
  localparam int FLD_W     = 2 * POS_W + COL_W,
  localparam int DATA_W    = ((FLD_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // line_byte
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // field_start, field_end, column, zero pad
  output logic              out_tlast,  // last_field
  output logic [1:0]        out_tuser,  // unbalanced, overflow
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  typedef struct packed {
    logic [POS_W-1:0]        field_start;
    logic [POS_W-1:0]        field_end;
    logic [COL_W-1:0]        column;
    csvfs_pkg::field_flags_t flags;
  } result_t;

  logic [7:0] sep_r, quote_r;

  logic                    in_fire;
  logic                    res_valid;
  logic [POS_W-1:0]        res_start, res_end;
  logic [COL_W-1:0]        res_column;
  csvfs_pkg::field_flags_t res_flags;
  result_t                 res;

  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r   <= csvfs_pkg::SEP_RESET;
      quote_r <= csvfs_pkg::QUOTE_RESET;
    end else if (cfg_valid) begin
      case (csvfs_pkg::cfg_idx_t'(cfg_index))
        csvfs_pkg::CFG_SEPARATOR: sep_r   <= cfg_data;
        csvfs_pkg::CFG_QUOTE:     quote_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  csvfs_core #(
    .MAX_LINE   (MAX_LINE),
    .MAX_FIELDS (MAX_FIELDS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (in_fire),
    .line_byte      (in_tdata),
    .separator_char (sep_r),
    .quote_char     (quote_r),
    .res_valid      (res_valid),
    .res_start      (res_start),
    .res_end        (res_end),
    .res_column     (res_column),
    .res_flags      (res_flags)
  );

  assign res = '{field_start: res_start, field_end: res_end,
                 column: res_column, flags: res_flags};

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (res_valid) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'({out_data_r.column, out_data_r.field_end,
                               out_data_r.field_start});
  assign out_tlast  = out_data_r.flags.last_field;
  assign out_tuser  = {out_data_r.flags.overflow, out_data_r.flags.unbalanced};

`ifndef SYNTH
  // The skid entry only ever holds data behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // The skid entry fills only when the output was stalled
  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready && res_valid))
    else $error("skid entry filled without a stall");

  // An open quote can only be reported on the line's last field
  a_unbal_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.flags.unbalanced |-> out_data_r.flags.last_field)
    else $error("unbalanced flag on a non-final field");

  // Field end is clamped so it never precedes the start
  a_end_ge_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.field_end >= out_data_r.field_start)
    else $error("field end below field start");
`endif

endmodule
